/* src/bmsi_pkg.sv */
package bmsi_pkg;

    localparam int ROM_OFFSET_W = 21;

    localparam logic [7:0] RESET_PRG_SIZE = 8'd2;

    // configuration register indexes
    localparam logic [7:0] CFG_PRG_SIZE    = 8'd0;
    localparam logic [7:0] CFG_FOUR_SCREEN = 8'd1;

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_TICK      = 2'd1,
        OP_CPU_XLATE = 2'd2,
        OP_PPU_XLATE = 2'd3
    } op_e_t;

    // 8 KB region of a register write, address bits 14:13
    typedef enum logic [1:0] {
        REGION_BANK       = 2'd0,
        REGION_MIRROR     = 2'd1,
        REGION_IRQ_LATCH  = 2'd2,
        REGION_IRQ_ENABLE = 2'd3
    } region_e_t;

    // target of a bank data write, bank select bits 2:0
    typedef enum logic [2:0] {
        BR_CHR2K_0 = 3'd0,
        BR_CHR2K_1 = 3'd1,
        BR_CHR1K_0 = 3'd2,
        BR_CHR1K_1 = 3'd3,
        BR_CHR1K_2 = 3'd4,
        BR_CHR1K_3 = 3'd5,
        BR_PRG_R6  = 3'd6,
        BR_PRG_R7  = 3'd7
    } bank_reg_e_t;

    localparam logic [1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIR_FOUR       = 2'd2;

    typedef struct packed {
        op_e_t       op;
        logic [15:0] address;
        logic [7:0]  value;
    } item_t;

    typedef struct packed {
        logic [1:0]              mirror_select;
        logic [ROM_OFFSET_W-1:0] rom_offset;
        logic                    out_of_range;
    } bank_res_t;

endpackage

/* src/bank_mapper_with_scanline_irq_top.sv */
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// input    | in_valid / in_ready    | operation, address, value
// result   | out_valid / out_ready  | irq, mirror_select, rom_offset, out_of_range
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
// One transaction per cycle while the result is not stalled: input register, then
// decode and state update, then result register, which offers the result.
// Mapper state changes at the edge that moves an item from input to result register.
// rst_n resets all mapper state to its defaults and clears both stage valid flags; no clearing pass.
// A stalled result holds its register; the input register still takes one
// transaction while it is empty, so in_ready drops only once both stages are full.
module bank_mapper_with_scanline_irq_top #(
    parameter int BANK_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [15:0] address,
    input  logic [7:0]  value,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        irq,
    output logic [1:0]  mirror_select,
    output logic [20:0] rom_offset,
    output logic        out_of_range,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import bmsi_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    item_t     s1_item_reg;
    logic      out_valid_reg, out_valid_next;
    logic      irq_reg;
    logic [1:0] mirror_select_reg;
    logic [ROM_OFFSET_W-1:0] rom_offset_reg;
    logic      out_of_range_reg;

    logic      in_take;
    logic      advance;
    logic      fire;
    bank_res_t bank_res;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.op      <= op_e_t'(operation);
            s1_item_reg.address <= address;
            s1_item_reg.value   <= value;
        end
        if (advance)
        begin
            irq_reg           <= fire;
            mirror_select_reg <= bank_res.mirror_select;
            rom_offset_reg    <= bank_res.rom_offset;
            out_of_range_reg  <= bank_res.out_of_range;
        end
    end

    bmsi_banks #(
        .BANK_BITS (BANK_BITS)
    ) u_banks (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .item      (s1_item_reg),
        .item_go   (advance),
        .res       (bank_res)
    );

    bmsi_irq u_irq (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (s1_item_reg),
        .item_go (advance),
        .fire    (fire)
    );

    assign out_valid     = out_valid_reg;
    assign irq           = irq_reg;
    assign mirror_select = mirror_select_reg;
    assign rom_offset    = rom_offset_reg;
    assign out_of_range  = out_of_range_reg;

    a_irq_only_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.op != OP_TICK) |=> !irq)
        else $error("irq on a non-tick transaction");

    a_oor_only_cpu: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_item_reg.op != OP_CPU_XLATE) |=> !out_of_range)
        else $error("out_of_range on a non-cpu transaction");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while both stages are full and stalled");

endmodule

/* src/bmsi_irq.sv */
module bmsi_irq (
    input  logic           clk,
    input  logic           rst_n,
    input  bmsi_pkg::item_t item,
    input  logic           item_go,
    output logic           fire
);
    import bmsi_pkg::*;

    logic [7:0] counter_reg, counter_next;
    logic [7:0] reload_value_reg, reload_value_next;
    logic       enabled_reg, enabled_next;
    logic       reload_pending_reg, reload_pending_next;
    logic       wr;
    logic       tick;
    logic       odd;

    assign odd  = item.address[0];
    assign wr   = item_go && (item.op == OP_WRITE) && item.address[15];
    assign tick = item_go && (item.op == OP_TICK);

    always_comb
    begin
        counter_next        = counter_reg;
        reload_value_next   = reload_value_reg;
        enabled_next        = enabled_reg;
        reload_pending_next = reload_pending_reg;
        fire                = 1'b0;
        if (wr)
        begin
            unique case (region_e_t'(item.address[14:13]))
                REGION_IRQ_LATCH:
                begin
                    if (odd)
                        reload_pending_next = 1'b1;
                    else
                        reload_value_next = item.value;
                end
                REGION_IRQ_ENABLE:
                    enabled_next = odd;
                REGION_BANK, REGION_MIRROR:
                    ;
            endcase
        end
        else if (tick)
        begin
            if (counter_reg == 8'd0 || reload_pending_reg)
            begin
                // a forced reload never raises the request
                fire                = enabled_reg && !reload_pending_reg;
                counter_next        = reload_value_reg;
                reload_pending_next = 1'b0;
            end
            else
            begin
                counter_next = counter_reg - 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg        <= '0;
            reload_value_reg   <= '0;
            enabled_reg        <= 1'b0;
            reload_pending_reg <= 1'b0;
        end
        else
        begin
            counter_reg        <= counter_next;
            reload_value_reg   <= reload_value_next;
            enabled_reg        <= enabled_next;
            reload_pending_reg <= reload_pending_next;
        end
    end

    a_tick_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        tick |=> !reload_pending_reg)
        else $error("reload still pending after a tick");

    a_fire_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (enabled_reg && tick))
        else $error("irq raised without enable or tick");

endmodule

/* src/bmsi_banks.sv */
module bmsi_banks #(
    parameter int BANK_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr,
    input  logic [7:0]        cfg_idx,
    input  logic [7:0]        cfg_wdata,
    input  bmsi_pkg::item_t   item,
    input  logic              item_go,
    output bmsi_pkg::bank_res_t res
);
    import bmsi_pkg::*;

    localparam logic [8:0] RESET_X2 = {RESET_PRG_SIZE, 1'b0};

    logic [7:0]           prg_size_reg, prg_size_next;
    logic                 four_screen_reg, four_screen_next;
    logic [7:0]           bank_select_reg, bank_select_next;
    logic                 mirror_reg, mirror_next;
    logic [BANK_BITS-1:0] cpu_bank_reg [4];
    logic [BANK_BITS-1:0] cpu_bank_next [4];
    logic [BANK_BITS-1:0] ppu_bank_reg [8];
    logic [BANK_BITS-1:0] ppu_bank_next [8];

    logic [8:0]           prg_x2;
    logic [8:0]           cfg_x2;
    logic [BANK_BITS-1:0] last_bank;
    logic [BANK_BITS-1:0] second_last;
    logic [BANK_BITS-1:0] cfg_last;
    logic [BANK_BITS-1:0] cfg_second_last;
    logic [BANK_BITS-1:0] r6_bank;
    logic [2:0]           chr2k_base;
    logic [1:0]           chr1k_sel;
    logic [1:0]           r6_idx;
    logic                 wr;
    logic                 odd;
    logic [BANK_BITS-1:0] cpu_bank;
    logic [BANK_BITS-1:0] ppu_bank;
    logic [ROM_OFFSET_W-1:0] cpu_off;
    logic [ROM_OFFSET_W-1:0] ppu_off;

    assign prg_x2          = {prg_size_reg, 1'b0};
    assign cfg_x2          = {cfg_wdata, 1'b0};
    assign last_bank       = BANK_BITS'(prg_x2 - 9'd1);
    assign second_last     = BANK_BITS'(prg_x2 - 9'd2);
    assign cfg_last        = BANK_BITS'(cfg_x2 - 9'd1);
    assign cfg_second_last = BANK_BITS'(cfg_x2 - 9'd2);

    assign wr  = item_go && (item.op == OP_WRITE) && item.address[15];
    assign odd = item.address[0];

    // bank-6 register sits in window 2 when bit 6 is set, else window 0
    assign r6_idx     = {bank_select_reg[6], 1'b0};
    assign r6_bank    = cpu_bank_reg[r6_idx];
    assign chr2k_base = {bank_select_reg[7], bank_select_reg[0], 1'b0};
    // registers 2..5 map to 1 KB slots 0..3
    assign chr1k_sel  = bank_select_reg[1:0] - 2'd2;

    always_comb
    begin
        prg_size_next    = prg_size_reg;
        four_screen_next = four_screen_reg;
        bank_select_next = bank_select_reg;
        mirror_next      = mirror_reg;
        cpu_bank_next    = cpu_bank_reg;
        ppu_bank_next    = ppu_bank_reg;
        if (cfg_wr)
        begin
            if (cfg_idx == CFG_PRG_SIZE)
            begin
                prg_size_next    = cfg_wdata;
                cpu_bank_next[3] = cfg_last;
                if (bank_select_reg[6])
                    cpu_bank_next[0] = cfg_second_last;
                else
                    cpu_bank_next[2] = cfg_second_last;
            end
            else if (cfg_idx == CFG_FOUR_SCREEN)
            begin
                four_screen_next = cfg_wdata[0];
            end
        end
        else if (wr)
        begin
            unique case (region_e_t'(item.address[14:13]))
                REGION_BANK:
                begin
                    if (odd)
                    begin
                        unique case (bank_reg_e_t'(bank_select_reg[2:0])) inside
                            BR_CHR2K_0, BR_CHR2K_1:
                            begin
                                ppu_bank_next[chr2k_base] =
                                    BANK_BITS'({item.value[7:1], 1'b0});
                                ppu_bank_next[chr2k_base | 3'd1] =
                                    BANK_BITS'({item.value[7:1], 1'b1});
                            end
                            BR_CHR1K_0, BR_CHR1K_1, BR_CHR1K_2, BR_CHR1K_3:
                                ppu_bank_next[{~bank_select_reg[7], chr1k_sel}] =
                                    BANK_BITS'(item.value);
                            BR_PRG_R6:
                                cpu_bank_next[r6_idx] = BANK_BITS'(item.value);
                            BR_PRG_R7:
                                cpu_bank_next[1] = BANK_BITS'(item.value);
                        endcase
                    end
                    else
                    begin
                        if (bank_select_reg[7] ^ item.value[7])
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                ppu_bank_next[i]     = ppu_bank_reg[i + 4];
                                ppu_bank_next[i + 4] = ppu_bank_reg[i];
                            end
                        end
                        bank_select_next = item.value;
                        if (item.value[6])
                        begin
                            cpu_bank_next[2] = r6_bank;
                            cpu_bank_next[0] = second_last;
                        end
                        else
                        begin
                            cpu_bank_next[0] = r6_bank;
                            cpu_bank_next[2] = second_last;
                        end
                    end
                end
                REGION_MIRROR:
                begin
                    if (!odd && !four_screen_reg)
                        mirror_next = item.value[0];
                end
                REGION_IRQ_LATCH, REGION_IRQ_ENABLE:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_size_reg    <= RESET_PRG_SIZE;
            four_screen_reg <= 1'b0;
            bank_select_reg <= '0;
            mirror_reg      <= 1'b0;
            cpu_bank_reg[0] <= '0;
            cpu_bank_reg[1] <= BANK_BITS'(1);
            cpu_bank_reg[2] <= BANK_BITS'(RESET_X2 - 9'd2);
            cpu_bank_reg[3] <= BANK_BITS'(RESET_X2 - 9'd1);
            for (int i = 0; i < 8; i++)
                ppu_bank_reg[i] <= BANK_BITS'(i);
        end
        else
        begin
            prg_size_reg    <= prg_size_next;
            four_screen_reg <= four_screen_next;
            bank_select_reg <= bank_select_next;
            mirror_reg      <= mirror_next;
            cpu_bank_reg    <= cpu_bank_next;
            ppu_bank_reg    <= ppu_bank_next;
        end
    end

    // translation
    assign cpu_bank = cpu_bank_reg[item.address[14:13]];
    assign ppu_bank = ppu_bank_reg[item.address[12:10]];
    assign cpu_off  = (ROM_OFFSET_W'(cpu_bank) << 13) | ROM_OFFSET_W'(item.address[12:0]);
    assign ppu_off  = (ROM_OFFSET_W'(ppu_bank) << 10) | ROM_OFFSET_W'(item.address[9:0]);

    always_comb
    begin
        if (four_screen_reg)
            res.mirror_select = MIR_FOUR;
        else if (mirror_next)
            res.mirror_select = MIR_HORIZONTAL;
        else
            res.mirror_select = MIR_VERTICAL;
        res.rom_offset   = '0;
        res.out_of_range = 1'b0;
        unique case (item.op)
            OP_CPU_XLATE:
            begin
                if (item.address[15])
                begin
                    res.rom_offset   = cpu_off;
                    res.out_of_range = (9'(cpu_bank) >= prg_x2);
                end
                else
                begin
                    res.out_of_range = 1'b1;
                end
            end
            OP_PPU_XLATE:
                res.rom_offset = ppu_off;
            OP_WRITE, OP_TICK:
                ;
        endcase
    end

    a_size_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && cfg_idx == CFG_PRG_SIZE) |=> (cpu_bank_reg[3] == $past(cfg_last)))
        else $error("fixed last bank not refreshed after size write");

endmodule

/* tb/sv/tb_bank_mapper_with_scanline_irq_top.sv */
module tb_bank_mapper_with_scanline_irq_top;

    import bmsi_pkg::*;

    localparam int         WATCHDOG_LIMIT  = 1000;
    localparam int         PHASE_ITEMS     = 80;
    localparam int         NUM_PHASES      = 6;
    localparam int         LONG_HOLD       = 80;
    localparam logic [7:0] CFG_NO_SUCH_REG = 8'hA5;

    typedef struct packed {
        logic                    irq;
        logic [1:0]              mirror_select;
        logic [ROM_OFFSET_W-1:0] rom_offset;
        logic                    out_of_range;
    } mapper_result_t;

    // Mapper state mirror plus the queue of results still owed by the block
    class mapper_tracker;
        logic [7:0]     prg_size;
        logic           four_scr;
        logic [7:0]     bank_sel;
        logic [7:0]     prg_win[4];
        logic [7:0]     chr_win[8];
        logic           mirror;
        logic [7:0]     irq_count;
        logic [7:0]     irq_latch;
        logic           irq_en;
        logic           reload_req;
        mapper_result_t owed_results[$];
        int             errors;

        function new();
            int i;
            prg_size   = RESET_PRG_SIZE;
            four_scr   = 1'b0;
            bank_sel   = '0;
            mirror     = 1'b0;
            irq_count  = '0;
            irq_latch  = '0;
            irq_en     = 1'b0;
            reload_req = 1'b0;
            errors     = 0;
            prg_win[0] = 8'd0;
            prg_win[1] = 8'd1;
            prg_win[2] = fixed_bank(2);
            prg_win[3] = fixed_bank(1);
            for (i = 0; i < 8; i++)
                chr_win[i] = 8'(i);
        endfunction

        // back = 1 gives the last bank, back = 2 the second-last
        function logic [7:0] fixed_bank(int back);
            return 8'(2 * int'(prg_size) - back);
        endfunction

        function void apply_config(logic [7:0] idx, logic [7:0] data);
            if (idx == CFG_PRG_SIZE) begin
                prg_size   = data;
                prg_win[3] = fixed_bank(1);
                if (bank_sel[6])
                    prg_win[0] = fixed_bank(2);
                else
                    prg_win[2] = fixed_bank(2);
            end
            else if (idx == CFG_FOUR_SCREEN)
                four_scr = data[0];
        endfunction

        function void write_select(logic [7:0] v);
            logic [7:0] r6;
            logic [7:0] t;
            int         i;
            r6 = bank_sel[6] ? prg_win[2] : prg_win[0];
            if (bank_sel[7] != v[7]) begin
                for (i = 0; i < 4; i++) begin
                    t              = chr_win[i];
                    chr_win[i]     = chr_win[i + 4];
                    chr_win[i + 4] = t;
                end
            end
            bank_sel = v;
            if (v[6]) begin
                prg_win[2] = r6;
                prg_win[0] = fixed_bank(2);
            end
            else begin
                prg_win[0] = r6;
                prg_win[2] = fixed_bank(2);
            end
        endfunction

        function void write_bank_data(logic [7:0] v);
            bank_reg_e_t breg;
            logic        inv;
            int          base;
            breg = bank_reg_e_t'(bank_sel[2:0]);
            inv  = bank_sel[7];
            case (breg)
                BR_CHR2K_0, BR_CHR2K_1:
                begin
                    // 2 KB pattern banks: even bank then the next one
                    base              = (inv ? 4 : 0) + ((breg == BR_CHR2K_1) ? 2 : 0);
                    chr_win[base]     = {v[7:1], 1'b0};
                    chr_win[base + 1] = {v[7:1], 1'b1};
                end
                BR_CHR1K_0, BR_CHR1K_1, BR_CHR1K_2, BR_CHR1K_3:
                begin
                    base          = (inv ? 0 : 4) + (int'(breg) - int'(BR_CHR1K_0));
                    chr_win[base] = v;
                end
                BR_PRG_R6:
                    prg_win[bank_sel[6] ? 2 : 0] = v;
                default:
                    prg_win[1] = v;
            endcase
        endfunction

        function void register_write(logic [15:0] addr, logic [7:0] v);
            logic odd;
            odd = addr[0];
            if (addr < 16'h8000)
                return;
            case (region_e_t'(addr[14:13]))
                REGION_BANK:
                begin
                    if (odd)
                        write_bank_data(v);
                    else
                        write_select(v);
                end
                REGION_MIRROR:
                begin
                    // odd writes here are program RAM protect, not modelled
                    if (!odd && !four_scr)
                        mirror = v[0];
                end
                REGION_IRQ_LATCH:
                begin
                    if (odd)
                        reload_req = 1'b1;
                    else
                        irq_latch = v;
                end
                default:
                    irq_en = odd;
            endcase
        endfunction

        function logic scanline_tick();
            logic fire;
            fire = 1'b0;
            if (irq_count == 8'd0 || reload_req) begin
                fire       = irq_en && !reload_req;
                irq_count  = irq_latch;
                reload_req = 1'b0;
            end
            else
                irq_count = irq_count - 8'd1;
            return fire;
        endfunction

        function mapper_result_t map_item(item_t it);
            mapper_result_t r;
            logic [7:0]     bank;
            r = '0;
            case (it.op)
                OP_WRITE:
                    register_write(it.address, it.value);
                OP_TICK:
                    r.irq = scanline_tick();
                OP_CPU_XLATE:
                begin
                    if (it.address < 16'h8000)
                        r.out_of_range = 1'b1;
                    else begin
                        bank           = prg_win[it.address[14:13]];
                        r.rom_offset   = ROM_OFFSET_W'(int'(bank) * 32'h2000
                                                       + int'(it.address[12:0]));
                        r.out_of_range = int'(bank) >= 2 * int'(prg_size);
                    end
                end
                default:
                begin
                    bank         = chr_win[it.address[12:10]];
                    r.rom_offset = ROM_OFFSET_W'(int'(bank) * 32'h400
                                                 + int'(it.address[9:0]));
                end
            endcase
            r.mirror_select = four_scr ? MIR_FOUR : (mirror ? MIR_HORIZONTAL : MIR_VERTICAL);
            return r;
        endfunction

        function void note_transaction(item_t it);
            owed_results.push_back(map_item(it));
        endfunction

        function void compare_field(string field, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, field, exp_v, act_v);
            end
        endfunction

        function void check_result(mapper_result_t act);
            mapper_result_t exp_r;
            if (owed_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing outstanding, actual 0x%0h", $time, act);
                return;
            end
            exp_r = owed_results.pop_front();
            compare_field("irq", exp_r.irq, act.irq);
            compare_field("mirror_select", exp_r.mirror_select, act.mirror_select);
            compare_field("rom_offset", exp_r.rom_offset, act.rom_offset);
            compare_field("out_of_range", exp_r.out_of_range, act.out_of_range);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  operation = '0;
    logic [15:0] address = '0;
    logic [7:0]  value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        irq;
    logic [1:0]  mirror_select;
    logic [20:0] rom_offset;
    logic        out_of_range;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    mapper_tracker tracker = new();
    int            idle_mode = 0;
    int            hold_off_left = 0;
    int            quiet_cycles = 0;

    bank_mapper_with_scanline_irq_top #(
        .BANK_BITS(8)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .address      (address),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .irq          (irq),
        .mirror_select(mirror_select),
        .rom_offset   (rom_offset),
        .out_of_range (out_of_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // receiver: random stalls by mode, plus the occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_off_left > 0) begin
            out_ready     <= 1'b0;
            hold_off_left = hold_off_left - 1;
        end
        else
            out_ready <= $urandom_range(0, 99) >= (idle_mode == 2 ? 71 :
                                                   idle_mode == 3 ? 12 : 0);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result({irq, mirror_select, rom_offset, out_of_range});
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic item_t mk_item(op_e_t op, logic [15:0] addr, logic [7:0] v);
        item_t it;
        it.op      = op;
        it.address = addr;
        it.value   = v;
        return it;
    endfunction

    function automatic item_t random_item();
        item_t it;
        it.op      = op_e_t'($urandom_range(0, 3));
        it.address = 16'($urandom);
        it.value   = 8'($urandom);
        case (it.op)
            OP_WRITE:
            begin
                if ($urandom_range(0, 9) != 0)
                    it.address[15] = 1'b1;
                if (it.address[14:13] == REGION_IRQ_LATCH && $urandom_range(0, 1) == 1)
                    it.value = 8'($urandom_range(0, 7));
            end
            OP_CPU_XLATE:
            begin
                if ($urandom_range(0, 7) != 0)
                    it.address[15] = 1'b1;
            end
            default:
            begin
            end
        endcase
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic offer_item(input item_t it);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 71 : (idle_mode == 3) ? 12 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        operation <= it.op;
        address   <= it.address;
        value     <= it.value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_transaction(it);
        @(negedge clk);
    endtask

    task automatic write_cfg_reg(input logic [7:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.apply_config(idx, data);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (tracker.owed_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        item_t      seq[$];
        int         prg_list[NUM_PHASES];
        int         fs_list[NUM_PHASES];
        int         phase;
        int         sent;
        int         k;
        int         ticks;
        logic [7:0] prg_val;

        prg_list = '{1, 128, 0, 255, 0, 2};
        fs_list  = '{1, 0, 1, 0, 0, 0};

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: window extremes, mode swaps, 2 KB banks, mirroring, IRQ reload and fire
        seq.push_back(mk_item(OP_PPU_XLATE, 16'h0000, 8'h00));
        seq.push_back(mk_item(OP_PPU_XLATE, 16'hFFFF, 8'hFF));
        seq.push_back(mk_item(OP_CPU_XLATE, 16'h8000, 8'h00));
        seq.push_back(mk_item(OP_CPU_XLATE, 16'hFFFF, 8'h00));
        seq.push_back(mk_item(OP_CPU_XLATE, 16'h7FFF, 8'h00));
        seq.push_back(mk_item(OP_WRITE, 16'h8000, {5'd0, BR_PRG_R6}));
        seq.push_back(mk_item(OP_WRITE, 16'h8001, 8'hFF));
        seq.push_back(mk_item(OP_CPU_XLATE, 16'h8123, 8'h00));
        seq.push_back(mk_item(OP_WRITE, 16'h8000, {2'b11, 3'd0, BR_CHR2K_0}));
        seq.push_back(mk_item(OP_CPU_XLATE, 16'hC000, 8'h00));
        seq.push_back(mk_item(OP_WRITE, 16'h8001, 8'h15));
        seq.push_back(mk_item(OP_PPU_XLATE, 16'h1000, 8'h00));
        seq.push_back(mk_item(OP_PPU_XLATE, 16'h17FF, 8'h00));
        seq.push_back(mk_item(OP_WRITE, 16'h8000, {5'd0, BR_CHR1K_3}));
        seq.push_back(mk_item(OP_WRITE, 16'h8001, 8'hAB));
        seq.push_back(mk_item(OP_PPU_XLATE, 16'h1C00, 8'h00));
        seq.push_back(mk_item(OP_WRITE, 16'hA000, 8'h01));
        seq.push_back(mk_item(OP_WRITE, 16'hA001, 8'h00));
        seq.push_back(mk_item(OP_WRITE, 16'h7000, 8'h80));
        seq.push_back(mk_item(OP_WRITE, 16'hC000, 8'h02));
        seq.push_back(mk_item(OP_WRITE, 16'hC001, 8'h00));
        seq.push_back(mk_item(OP_WRITE, 16'hE001, 8'h00));
        for (k = 0; k < 4; k++)
            seq.push_back(mk_item(OP_TICK, 16'h0000, 8'h00));
        seq.push_back(mk_item(OP_WRITE, 16'hE000, 8'h00));
        seq.push_back(mk_item(OP_TICK, 16'hFFFF, 8'hFF));
        foreach (seq[i])
            offer_item(seq[i]);
        in_valid <= 1'b0;

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            prg_val = (phase == 4) ? 8'($urandom_range(1, 128)) : 8'(prg_list[phase]);
            if (phase == 0)
                write_cfg_reg(CFG_NO_SUCH_REG, 8'($urandom));
            write_cfg_reg(CFG_FOUR_SCREEN, (phase == 4) ? 8'($urandom) : 8'(fs_list[phase]));
            write_cfg_reg(CFG_PRG_SIZE, prg_val);
            cfg_valid <= 1'b0;
            idle_mode = phase % 4;
            if (phase == 4)
                hold_off_left = LONG_HOLD;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    // counter programming followed by a run of scanlines
                    offer_item(mk_item(OP_WRITE, 16'hC000, 8'($urandom_range(0, 5))));
                    offer_item(mk_item(OP_WRITE, 16'hC001, 8'($urandom)));
                    offer_item(mk_item(OP_WRITE, 16'hE001, 8'($urandom)));
                    ticks = $urandom_range(1, 10);
                    for (k = 0; k < ticks; k++)
                        offer_item(mk_item(OP_TICK, 16'($urandom), 8'($urandom)));
                    sent += 3 + ticks;
                end
                else begin
                    offer_item(random_item());
                    sent++;
                end
            end
            in_valid <= 1'b0;
        end

        while (tracker.owed_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.owed_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
